[rtl/servo_jog_command_decoder_top_defines.svh]
// Shared assertion macros
`ifndef SERVO_JOG_COMMAND_DECODER_TOP_DEFINES_SVH
`define SERVO_JOG_COMMAND_DECODER_TOP_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define SJCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define SJCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sjcd_pkg.sv]
package sjcd_pkg;

    localparam int DUTY_W      = 16;
    localparam int STEP_W      = 12;
    localparam int SERVO_N     = 5;
    localparam int SERVO_IDX_W = $clog2(SERVO_N);
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    localparam logic [DUTY_W-1:0] DUTY_UPPER_RST    = 16'd6200;
    localparam logic [DUTY_W-1:0] DUTY_LOWER_RST    = 16'd3100;
    localparam logic [DUTY_W-1:0] GRIP_UPPER_RST    = 16'd6200;
    localparam logic [DUTY_W-1:0] GRIP_LOWER_RST    = 16'd3100;
    localparam logic [STEP_W-1:0] JOG_STEP_RST      = 12'd50;
    localparam logic [DUTY_W-1:0] MIN_CLEARANCE_RST = 16'd5;
    localparam logic [DUTY_W-1:0] DUTY_RST          = 16'd4650;

    typedef enum logic [2:0] {
        REG_DUTY_UPPER    = 3'd0,
        REG_DUTY_LOWER    = 3'd1,
        REG_GRIP_UPPER    = 3'd2,
        REG_GRIP_LOWER    = 3'd3,
        REG_JOG_STEP      = 3'd4,
        REG_MIN_CLEARANCE = 3'd5
    } t_reg_idx;

    localparam logic [SERVO_IDX_W-1:0] SERVO_BASE     = 3'd0;
    localparam logic [SERVO_IDX_W-1:0] SERVO_SHOULDER = 3'd1;
    localparam logic [SERVO_IDX_W-1:0] SERVO_ELBOW    = 3'd2;
    localparam logic [SERVO_IDX_W-1:0] SERVO_WRIST    = 3'd3;
    localparam logic [SERVO_IDX_W-1:0] SERVO_GRIP     = 3'd4;

    localparam logic [7:0] KEY_RESTART     = 8'h69; // i
    localparam logic [7:0] KEY_PAUSE       = 8'h6f; // o
    localparam logic [7:0] KEY_RESUME      = 8'h70; // p
    localparam logic [7:0] KEY_BASE_UP     = 8'h61; // a
    localparam logic [7:0] KEY_BASE_DN     = 8'h64; // d
    localparam logic [7:0] KEY_SHOULDER_UP = 8'h77; // w
    localparam logic [7:0] KEY_SHOULDER_DN = 8'h73; // s
    localparam logic [7:0] KEY_ELBOW_UP    = 8'h72; // r
    localparam logic [7:0] KEY_ELBOW_DN    = 8'h66; // f
    localparam logic [7:0] KEY_WRIST_UP    = 8'h79; // y
    localparam logic [7:0] KEY_WRIST_DN    = 8'h68; // h
    localparam logic [7:0] KEY_GRIP_UP     = 8'h67; // g
    localparam logic [7:0] KEY_GRIP_DN     = 8'h6a; // j

    typedef struct packed {
        logic [7:0]        rx_byte;
        logic              auto_mode_active;
        logic              safe_pose_active;
        logic [DUTY_W-1:0] distance_cm;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_base;
        logic [DUTY_W-1:0] duty_shoulder;
        logic [DUTY_W-1:0] duty_elbow;
        logic [DUTY_W-1:0] duty_wrist;
        logic [DUTY_W-1:0] duty_grip;
        logic              stopwatch_running;
        logic              stopwatch_restart;
    } t_out_item;

    typedef struct packed {
        logic [SERVO_N-1:0][DUTY_W-1:0] duty;
        logic                           run_bit;
    } t_state_row;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_upper;
        logic [DUTY_W-1:0] duty_lower;
        logic [DUTY_W-1:0] grip_upper;
        logic [DUTY_W-1:0] grip_lower;
        logic [STEP_W-1:0] jog_step;
        logic [DUTY_W-1:0] min_clearance;
    } t_limits;

    localparam t_state_row STATE_RST = '{duty: {SERVO_N{DUTY_RST}}, run_bit: 1'b0};

endpackage

[rtl/sjcd_jog.sv]
module sjcd_jog (
    input  sjcd_pkg::t_state_row i_row,
    input  sjcd_pkg::t_in_item   i_item,
    input  sjcd_pkg::t_limits    i_lim,
    output sjcd_pkg::t_state_row o_row,
    output logic                 o_restart
);
    import sjcd_pkg::*;

    logic                   hit;
    logic                   dir_up;
    logic [SERVO_IDX_W-1:0] idx;
    logic                   locked;
    logic                   clear_ok;
    logic [DUTY_W-1:0]      cur;
    logic [DUTY_W-1:0]      upper;
    logic [DUTY_W-1:0]      lower;
    logic [DUTY_W:0]        up_sum;
    logic [DUTY_W:0]        dn_bound;
    logic [DUTY_W-1:0]      up_val;
    logic [DUTY_W-1:0]      dn_val;
    logic                   run_next;

    assign locked   = i_item.auto_mode_active | i_item.safe_pose_active;
    assign clear_ok = i_item.distance_cm > i_lim.min_clearance;

    always_comb begin
        hit    = 1'b0;
        dir_up = 1'b0;
        idx    = SERVO_BASE;
        unique case (i_item.rx_byte)
            KEY_BASE_UP: begin
                hit = 1'b1; dir_up = 1'b1; idx = SERVO_BASE;
            end
            KEY_BASE_DN: begin
                hit = 1'b1; idx = SERVO_BASE;
            end
            KEY_SHOULDER_UP: begin
                hit = 1'b1; dir_up = 1'b1; idx = SERVO_SHOULDER;
            end
            KEY_SHOULDER_DN: begin
                hit = 1'b1; idx = SERVO_SHOULDER;
            end
            KEY_ELBOW_UP: begin
                hit = clear_ok; dir_up = 1'b1; idx = SERVO_ELBOW;
            end
            KEY_ELBOW_DN: begin
                hit = 1'b1; idx = SERVO_ELBOW;
            end
            KEY_WRIST_UP: begin
                hit = 1'b1; dir_up = 1'b1; idx = SERVO_WRIST;
            end
            KEY_WRIST_DN: begin
                hit = 1'b1; idx = SERVO_WRIST;
            end
            KEY_GRIP_UP: begin
                hit = 1'b1; dir_up = 1'b1; idx = SERVO_GRIP;
            end
            KEY_GRIP_DN: begin
                hit = 1'b1; idx = SERVO_GRIP;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    always_comb begin
        run_next  = i_row.run_bit;
        o_restart = 1'b0;
        unique case (i_item.rx_byte)
            KEY_RESTART: begin
                run_next  = 1'b0;
                o_restart = 1'b1;
            end
            KEY_PAUSE: begin
                run_next = 1'b0;
            end
            KEY_RESUME: begin
                run_next = 1'b1;
            end
            default: begin
                run_next = i_row.run_bit;
            end
        endcase
    end

    assign cur   = i_row.duty[idx];
    assign upper = (idx == SERVO_GRIP) ? i_lim.grip_upper : i_lim.duty_upper;
    assign lower = (idx == SERVO_GRIP) ? i_lim.grip_lower : i_lim.duty_lower;

    // d - step > lower  <=>  d > lower + step
    assign up_sum   = {1'b0, cur} + {{(DUTY_W+1-STEP_W){1'b0}}, i_lim.jog_step};
    assign dn_bound = {1'b0, lower} + {{(DUTY_W+1-STEP_W){1'b0}}, i_lim.jog_step};
    assign up_val   = (up_sum < {1'b0, upper}) ? up_sum[DUTY_W-1:0] : upper;
    assign dn_val   = ({1'b0, cur} > dn_bound)
                    ? cur - {{(DUTY_W-STEP_W){1'b0}}, i_lim.jog_step} : lower;

    always_comb begin
        o_row         = i_row;
        o_row.run_bit = run_next;
        if (hit && !locked) begin
            o_row.duty[idx] = dir_up ? up_val : dn_val;
        end
    end

endmodule

[rtl/servo_jog_command_decoder_top.sv]
// Channel | Dir | Handshake                | Payload
// in      | in  | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
// out     | out | o_out_valid / i_out_ready| o_out_data (t_out_item)
// cfg     | in  | psel, penable, pwrite    | paddr, pwdata, prdata, pready
//
// One item per cycle unless output stalls; results pass s1, then output reg.
// State row sits in a one-entry memory; read at accept, written back
// on leaving s1, with forwarding when the next item reads in that cycle.
// Synchronous active-low reset; the state row reads as reset until written.
// A stalled output holds one result; input stalls only when it is full.
module servo_jog_command_decoder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sjcd_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sjcd_pkg::t_out_item                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sjcd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sjcd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sjcd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import sjcd_pkg::*;

    t_limits    r_lim;
    t_state_row r_state_mem [1];
    logic       r_mem_vld;
    t_state_row r_rd_row;
    logic       r_fwd;
    t_state_row r_fwd_row;
    logic       r_s1_vld;
    t_in_item   r_s1_item;
    logic       r_out_vld;
    t_out_item  r_out_item;

    t_state_row cur_row;
    t_state_row jog_row;
    logic       jog_restart;
    logic       in_fire;
    logic       s1_fire;
    logic       cfg_wr;
    t_reg_idx   reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim.duty_upper    <= DUTY_UPPER_RST;
            r_lim.duty_lower    <= DUTY_LOWER_RST;
            r_lim.grip_upper    <= GRIP_UPPER_RST;
            r_lim.grip_lower    <= GRIP_LOWER_RST;
            r_lim.jog_step      <= JOG_STEP_RST;
            r_lim.min_clearance <= MIN_CLEARANCE_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_DUTY_UPPER:    r_lim.duty_upper    <= pwdata[DUTY_W-1:0];
                REG_DUTY_LOWER:    r_lim.duty_lower    <= pwdata[DUTY_W-1:0];
                REG_GRIP_UPPER:    r_lim.grip_upper    <= pwdata[DUTY_W-1:0];
                REG_GRIP_LOWER:    r_lim.grip_lower    <= pwdata[DUTY_W-1:0];
                REG_JOG_STEP:      r_lim.jog_step      <= pwdata[STEP_W-1:0];
                REG_MIN_CLEARANCE: r_lim.min_clearance <= pwdata[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_DUTY_UPPER:    prdata = APB_DATA_W'(r_lim.duty_upper);
            REG_DUTY_LOWER:    prdata = APB_DATA_W'(r_lim.duty_lower);
            REG_GRIP_UPPER:    prdata = APB_DATA_W'(r_lim.grip_upper);
            REG_GRIP_LOWER:    prdata = APB_DATA_W'(r_lim.grip_lower);
            REG_JOG_STEP:      prdata = APB_DATA_W'(r_lim.jog_step);
            REG_MIN_CLEARANCE: prdata = APB_DATA_W'(r_lim.min_clearance);
            default:           prdata = '0;
        endcase
    end

    assign s1_fire    = r_s1_vld & (~r_out_vld | i_out_ready);
    assign o_in_ready = ~r_s1_vld | s1_fire;
    assign in_fire    = i_in_valid & o_in_ready;

    // state memory: write-back port
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_state_mem[0] <= jog_row;
        end
    end

    // state memory: registered read port
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_row  <= r_mem_vld ? r_state_mem[0] : STATE_RST;
            r_fwd_row <= jog_row;
            r_s1_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= 1'b0;
            r_fwd     <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_fire) begin
                r_mem_vld <= 1'b1;
            end
            if (in_fire) begin
                r_fwd <= s1_fire;
            end
            if (in_fire) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign cur_row = r_fwd ? r_fwd_row : r_rd_row;

    sjcd_jog u_jog (
        .i_row     (cur_row),
        .i_item    (r_s1_item),
        .i_lim     (r_lim),
        .o_row     (jog_row),
        .o_restart (jog_restart)
    );

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_item.duty_base         <= jog_row.duty[SERVO_BASE];
            r_out_item.duty_shoulder     <= jog_row.duty[SERVO_SHOULDER];
            r_out_item.duty_elbow        <= jog_row.duty[SERVO_ELBOW];
            r_out_item.duty_wrist        <= jog_row.duty[SERVO_WRIST];
            r_out_item.duty_grip         <= jog_row.duty[SERVO_GRIP];
            r_out_item.stopwatch_running <= jog_row.run_bit;
            r_out_item.stopwatch_restart <= jog_restart;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_item;

endmodule

[rtl/sjcd_checker.sv]
`include "servo_jog_command_decoder_top_defines.svh"

module sjcd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input sjcd_pkg::t_in_item              i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input sjcd_pkg::t_out_item             o_out_data,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [sjcd_pkg::APB_ADDR_W-1:0] paddr,
    input logic [sjcd_pkg::APB_DATA_W-1:0] pwdata,
    input logic [sjcd_pkg::APB_DATA_W-1:0] prdata,
    input logic                            pready
);
    import sjcd_pkg::*;

    `SJCD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data), "stalled item changed")

    `SJCD_ASSERT_SAME(a_restart_stops, o_out_valid && o_out_data.stopwatch_restart,
        !o_out_data.stopwatch_running, "restart item shows running stopwatch")

    `SJCD_ASSERT_SAME(a_backpressure, !o_in_ready,
        o_out_valid && !i_out_ready, "input stalled without a stalled output")

    `SJCD_ASSERT_SAME(a_pready, 1'b1, pready, "pready dropped")

endmodule

bind servo_jog_command_decoder_top sjcd_checker u_sjcd_checker (.*);

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import sjcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_GAP        = 40;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    servo_jog_command_decoder_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // shadow copy of the decoder
    t_limits           lim_shadow;
    logic [DUTY_W-1:0] duty_shadow [SERVO_N];
    logic              run_shadow;

    t_out_item pending_readouts [$];
    int        items_sent      = 0;
    int        results_checked = 0;
    int        fault_count     = 0;
    int        limit_settings  = 0;
    int        send_idle_pct   = 0;
    int        recv_stall_pct  = 0;
    int        quiet_cycles    = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [DUTY_W-1:0] raise_duty(logic [DUTY_W-1:0] d,
                                                     logic [DUTY_W-1:0] upper);
        int stepped;
        stepped = int'(d) + int'(lim_shadow.jog_step);
        return (stepped < int'(upper)) ? stepped[DUTY_W-1:0] : upper;
    endfunction

    function automatic logic [DUTY_W-1:0] lower_duty(logic [DUTY_W-1:0] d,
                                                     logic [DUTY_W-1:0] lower);
        int stepped;
        stepped = int'(d) - int'(lim_shadow.jog_step);
        return (stepped > int'(lower)) ? stepped[DUTY_W-1:0] : lower;
    endfunction

    function automatic t_out_item predict_readout(t_in_item cmd);
        t_out_item r;
        logic      locked;
        logic      restart;
        locked  = cmd.auto_mode_active | cmd.safe_pose_active;
        restart = 1'b0;
        case (cmd.rx_byte)
            KEY_RESTART: begin
                run_shadow = 1'b0;
                restart    = 1'b1;
            end
            KEY_PAUSE:  run_shadow = 1'b0;
            KEY_RESUME: run_shadow = 1'b1;
            default: ;
        endcase
        if (!locked) begin
            case (cmd.rx_byte)
                KEY_BASE_UP: duty_shadow[SERVO_BASE] =
                    raise_duty(duty_shadow[SERVO_BASE], lim_shadow.duty_upper);
                KEY_BASE_DN: duty_shadow[SERVO_BASE] =
                    lower_duty(duty_shadow[SERVO_BASE], lim_shadow.duty_lower);
                KEY_SHOULDER_UP: duty_shadow[SERVO_SHOULDER] =
                    raise_duty(duty_shadow[SERVO_SHOULDER], lim_shadow.duty_upper);
                KEY_SHOULDER_DN: duty_shadow[SERVO_SHOULDER] =
                    lower_duty(duty_shadow[SERVO_SHOULDER], lim_shadow.duty_lower);
                KEY_ELBOW_UP: begin
                    if (cmd.distance_cm > lim_shadow.min_clearance)
                        duty_shadow[SERVO_ELBOW] =
                            raise_duty(duty_shadow[SERVO_ELBOW], lim_shadow.duty_upper);
                end
                KEY_ELBOW_DN: duty_shadow[SERVO_ELBOW] =
                    lower_duty(duty_shadow[SERVO_ELBOW], lim_shadow.duty_lower);
                KEY_WRIST_UP: duty_shadow[SERVO_WRIST] =
                    raise_duty(duty_shadow[SERVO_WRIST], lim_shadow.duty_upper);
                KEY_WRIST_DN: duty_shadow[SERVO_WRIST] =
                    lower_duty(duty_shadow[SERVO_WRIST], lim_shadow.duty_lower);
                KEY_GRIP_UP: duty_shadow[SERVO_GRIP] =
                    raise_duty(duty_shadow[SERVO_GRIP], lim_shadow.grip_upper);
                KEY_GRIP_DN: duty_shadow[SERVO_GRIP] =
                    lower_duty(duty_shadow[SERVO_GRIP], lim_shadow.grip_lower);
                default: ;
            endcase
        end
        r.duty_base         = duty_shadow[SERVO_BASE];
        r.duty_shoulder     = duty_shadow[SERVO_SHOULDER];
        r.duty_elbow        = duty_shadow[SERVO_ELBOW];
        r.duty_wrist        = duty_shadow[SERVO_WRIST];
        r.duty_grip         = duty_shadow[SERVO_GRIP];
        r.stopwatch_running = run_shadow;
        r.stopwatch_restart = restart;
        return r;
    endfunction

    task automatic check_field(string field_name, logic [DUTY_W-1:0] expected,
                               logic [DUTY_W-1:0] actual);
        if (expected !== actual) begin
            fault_count++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, field_name, expected, actual);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readouts.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected result, expected none actual %h",
                         $time, o_out_data);
            end else begin
                exp_item = pending_readouts.pop_front();
                results_checked++;
                check_field("duty_base", exp_item.duty_base, o_out_data.duty_base);
                check_field("duty_shoulder", exp_item.duty_shoulder,
                            o_out_data.duty_shoulder);
                check_field("duty_elbow", exp_item.duty_elbow, o_out_data.duty_elbow);
                check_field("duty_wrist", exp_item.duty_wrist, o_out_data.duty_wrist);
                check_field("duty_grip", exp_item.duty_grip, o_out_data.duty_grip);
                check_field("stopwatch_running", 16'(exp_item.stopwatch_running),
                            16'(o_out_data.stopwatch_running));
                check_field("stopwatch_restart", 16'(exp_item.stopwatch_restart),
                            16'(o_out_data.stopwatch_restart));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_pacing(int send_pct, int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic send_command(t_in_item cmd);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= cmd;
        do @(posedge i_clk); while (!o_in_ready);
        pending_readouts.push_back(predict_readout(cmd));
        items_sent++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(t_reg_idx idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_DUTY_UPPER:    lim_shadow.duty_upper    = value[DUTY_W-1:0];
            REG_DUTY_LOWER:    lim_shadow.duty_lower    = value[DUTY_W-1:0];
            REG_GRIP_UPPER:    lim_shadow.grip_upper    = value[DUTY_W-1:0];
            REG_GRIP_LOWER:    lim_shadow.grip_lower    = value[DUTY_W-1:0];
            REG_JOG_STEP:      lim_shadow.jog_step      = value[STEP_W-1:0];
            REG_MIN_CLEARANCE: lim_shadow.min_clearance = value[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_limits(t_limits lim);
        wait_drain();
        write_register(REG_DUTY_UPPER, 32'(lim.duty_upper));
        write_register(REG_DUTY_LOWER, 32'(lim.duty_lower));
        write_register(REG_GRIP_UPPER, 32'(lim.grip_upper));
        write_register(REG_GRIP_LOWER, 32'(lim.grip_lower));
        write_register(REG_JOG_STEP, 32'(lim.jog_step));
        write_register(REG_MIN_CLEARANCE, 32'(lim.min_clearance));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        limit_settings++;
    endtask

    function automatic t_in_item make_command(logic [7:0] key, logic auto_on,
                                              logic safe_on, logic [DUTY_W-1:0] distance);
        t_in_item cmd;
        cmd.rx_byte          = key;
        cmd.auto_mode_active = auto_on;
        cmd.safe_pose_active = safe_on;
        cmd.distance_cm      = distance;
        return cmd;
    endfunction

    function automatic logic [7:0] pick_key();
        case ($urandom_range(0, 12))
            0:       return KEY_RESTART;
            1:       return KEY_PAUSE;
            2:       return KEY_RESUME;
            3:       return KEY_BASE_UP;
            4:       return KEY_BASE_DN;
            5:       return KEY_SHOULDER_UP;
            6:       return KEY_SHOULDER_DN;
            7:       return KEY_ELBOW_UP;
            8:       return KEY_ELBOW_DN;
            9:       return KEY_WRIST_UP;
            10:      return KEY_WRIST_DN;
            11:      return KEY_GRIP_UP;
            default: return KEY_GRIP_DN;
        endcase
    endfunction

    function automatic t_in_item random_command();
        t_in_item cmd;
        int       near;
        cmd.rx_byte = ($urandom_range(0, 99) < 75) ? pick_key() : 8'($urandom_range(0, 255));
        cmd.auto_mode_active = ($urandom_range(0, 99) < 12);
        cmd.safe_pose_active = ($urandom_range(0, 99) < 12);
        case ($urandom_range(0, 3))
            0: begin
                near = int'(lim_shadow.min_clearance) + $urandom_range(0, 2) - 1;
                if (near < 0)
                    near = 0;
                if (near > 65535)
                    near = 65535;
                cmd.distance_cm = near[DUTY_W-1:0];
            end
            1:       cmd.distance_cm = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: cmd.distance_cm = 16'($urandom_range(0, 65535));
        endcase
        return cmd;
    endfunction

    function automatic t_limits random_limits(bit crossed);
        t_limits lim;
        int      a;
        int      b;
        a = $urandom_range(0, 65535);
        b = $urandom_range(0, 65535);
        lim.duty_upper = (crossed ^ (a > b)) ? a[DUTY_W-1:0] : b[DUTY_W-1:0];
        lim.duty_lower = (crossed ^ (a > b)) ? b[DUTY_W-1:0] : a[DUTY_W-1:0];
        a = $urandom_range(0, 65535);
        b = $urandom_range(0, 65535);
        lim.grip_upper = (crossed ^ (a > b)) ? a[DUTY_W-1:0] : b[DUTY_W-1:0];
        lim.grip_lower = (crossed ^ (a > b)) ? b[DUTY_W-1:0] : a[DUTY_W-1:0];
        lim.jog_step = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(1, 4095))
                                                   : 12'($urandom_range(1, 600));
        lim.min_clearance = 16'($urandom_range(0, 200));
        return lim;
    endfunction

    task automatic run_random_items(int count, int pause_every);
        for (int n = 0; n < count; n++) begin
            send_command(random_command());
            if (pause_every > 0 && n % pause_every == pause_every - 1)
                wait_drain();
        end
    endtask

    task automatic test_reset_and_stopwatch();
        set_pacing(0, 0);
        send_command(make_command("x", 1'b1, 1'b1, 16'hFFFF));
        send_command(make_command(8'h00, 1'b0, 1'b0, 16'h0000));
        send_command(make_command(KEY_RESUME, 1'b1, 1'b0, 16'd10));
        send_command(make_command(KEY_RESTART, 1'b0, 1'b1, 16'd10));
        send_command(make_command(KEY_PAUSE, 1'b0, 1'b0, 16'd10));
    endtask

    task automatic test_servo_keys();
        send_command(make_command(KEY_BASE_UP, 1'b0, 1'b0, 16'd100));
        send_command(make_command(KEY_BASE_DN, 1'b0, 1'b0, 16'd100));
        send_command(make_command(KEY_SHOULDER_UP, 1'b0, 1'b0, 16'd100));
        send_command(make_command(KEY_SHOULDER_DN, 1'b0, 1'b0, 16'd100));
        send_command(make_command(KEY_ELBOW_UP, 1'b0, 1'b0, 16'd100));
        send_command(make_command(KEY_ELBOW_DN, 1'b0, 1'b0, 16'd100));
        send_command(make_command(KEY_WRIST_UP, 1'b0, 1'b0, 16'd100));
        send_command(make_command(KEY_WRIST_DN, 1'b0, 1'b0, 16'd100));
        send_command(make_command(KEY_GRIP_UP, 1'b0, 1'b0, 16'd100));
        send_command(make_command(KEY_GRIP_DN, 1'b0, 1'b0, 16'd100));
        send_command(make_command(KEY_BASE_UP, 1'b1, 1'b0, 16'd100));
        send_command(make_command(KEY_ELBOW_UP, 1'b0, 1'b0, MIN_CLEARANCE_RST));
    endtask

    task automatic test_limit_corners();
        t_limits lim;
        lim = lim_shadow;
        lim.duty_upper = 16'd3000;
        lim.duty_lower = 16'd6000;
        apply_limits(lim);
        send_command(make_command(KEY_BASE_UP, 1'b0, 1'b0, 16'd100));
        send_command(make_command(KEY_BASE_DN, 1'b0, 1'b0, 16'd100));
        lim.jog_step = '0;
        apply_limits(lim);
        send_command(make_command(KEY_GRIP_UP, 1'b0, 1'b0, 16'd100));
        send_command(make_command(KEY_GRIP_DN, 1'b0, 1'b0, 16'd100));
        lim.jog_step   = JOG_STEP_RST;
        lim.duty_upper = 16'd4000;
        lim.duty_lower = 16'd4500;
        apply_limits(lim);
        send_command(make_command(KEY_WRIST_UP, 1'b0, 1'b0, 16'd100));
        send_command(make_command(KEY_WRIST_DN, 1'b0, 1'b0, 16'd100));
        lim = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 12'hFFF, 16'hFFFF};
        apply_limits(lim);
        send_command(make_command(KEY_SHOULDER_UP, 1'b0, 1'b0, 16'hFFFF));
        send_command(make_command(KEY_SHOULDER_DN, 1'b0, 1'b0, 16'hFFFF));
    endtask

    task automatic test_random_traffic();
        apply_limits('{DUTY_UPPER_RST, DUTY_LOWER_RST, GRIP_UPPER_RST, GRIP_LOWER_RST,
                       JOG_STEP_RST, MIN_CLEARANCE_RST});
        set_pacing(0, 0);
        run_random_items(60, 0);
        apply_limits(random_limits(1'b0));
        set_pacing(84, 0);
        run_random_items(80, 0);
        apply_limits('{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 12'hFFF, 16'h0000});
        set_pacing(0, 84);
        run_random_items(70, 0);
        apply_limits('{16'd4700, 16'd4600, 16'd4660, 16'd4640, 12'd1, 16'hFFFF});
        set_pacing(7, 7);
        run_random_items(70, 0);
        apply_limits(random_limits(1'b1));
        set_pacing(84, 84);
        run_random_items(60, 0);
    endtask

    // sender holds off every 20 items until the decoder has delivered everything
    task automatic test_drain_pauses();
        apply_limits(random_limits(1'b0));
        set_pacing(7, 7);
        run_random_items(60, 20);
    endtask

    initial begin
        lim_shadow = '{DUTY_UPPER_RST, DUTY_LOWER_RST, GRIP_UPPER_RST, GRIP_LOWER_RST,
                       JOG_STEP_RST, MIN_CLEARANCE_RST};
        for (int k = 0; k < SERVO_N; k++)
            duty_shadow[k] = DUTY_RST;
        run_shadow = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_and_stopwatch();
        test_servo_keys();
        test_limit_corners();
        test_random_traffic();
        test_drain_pauses();

        wait_drain();
        if (pending_readouts.size() != 0)
            fault_count++;
        $display("Sent %0d commands over %0d limit settings, five pacing modes.",
                 items_sent, limit_settings);
        $display("Checked %0d readouts; %0d field faults.", results_checked, fault_count);
        if (fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[servo_jog_command_decoder_top.f]
+incdir+rtl
rtl/sjcd_pkg.sv
rtl/sjcd_jog.sv
rtl/servo_jog_command_decoder_top.sv
rtl/sjcd_checker.sv
test/testbench.sv
